>>> sv/dqu_pkg.sv
// Shared types and constants for the double-ended queue unit.
package dqu_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 3;

    // Operation codes carried by each transfer.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    // Command broadcast to every cell of one chain.
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_PUSH_HEAD = 2'd1,
        CELL_POP_HEAD  = 2'd2,
        CELL_PUSH_TAIL = 2'd3
    } t_cell_op;

endpackage

>>> sv/dqu_cell.sv
// One storage cell of a chain: holds one word and trades it with its neighbors.
module dqu_cell #(
    parameter int W = 32
) (
    input  logic              i_clk,
    input  dqu_pkg::t_cell_op i_cmd,
    input  logic              i_at_tail,
    input  logic [W-1:0]      i_value,
    input  logic [W-1:0]      i_lo_word,
    input  logic [W-1:0]      i_hi_word,
    output logic [W-1:0]      o_word
);
    import dqu_pkg::*;

    logic [W-1:0] r_word;
    logic [W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd)
            CELL_PUSH_HEAD: n_word = i_lo_word;
            CELL_POP_HEAD:  n_word = i_hi_word;
            CELL_PUSH_TAIL: begin
                if (i_at_tail) begin
                    n_word = i_value;
                end
            end
            default:        n_word = r_word;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

>>> sv/dqu_chain.sv
// Row of cells holding the queue in order from one end; cell 0 is that end.
module dqu_chain #(
    parameter int DEPTH = 16,
    parameter int W     = 32,
    parameter int CW    = 5
) (
    input  logic              i_clk,
    input  dqu_pkg::t_cell_op i_cmd,
    input  logic [W-1:0]      i_value,
    input  logic [CW-1:0]     i_count,
    output logic [W-1:0]      o_head_word
);
    import dqu_pkg::*;

    logic [W-1:0] w_word [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [W-1:0] w_lo;
        logic [W-1:0] w_hi;

        // cell 0 takes the new word on a head push
        if (gi == 0) begin : g_first
            assign w_lo = i_value;
        end else begin : g_mid_lo
            assign w_lo = w_word[gi-1];
        end

        // last cell keeps its word on a head pop; it falls out of range anyway
        if (gi == DEPTH - 1) begin : g_last
            assign w_hi = w_word[gi];
        end else begin : g_mid_hi
            assign w_hi = w_word[gi+1];
        end

        dqu_cell #(
            .W (W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (i_cmd),
            .i_at_tail (i_count == CW'(gi)),
            .i_value   (i_value),
            .i_lo_word (w_lo),
            .i_hi_word (w_hi),
            .o_word    (w_word[gi])
        );
    end

    assign o_head_word = w_word[0];

endmodule

>>> sv/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: control, count and two cell chains.
//
// Bounded double-ended queue of up to DEPTH words. Each transfer (start high
// while busy is low) carries one operation: push front, push back, pop front,
// pop back or clear. busy never rises, so a new operation can be issued in
// every clock cycle. The result of an operation appears on the o_ ports in the
// cycle after its transfer, marked by o_valid for exactly that one cycle; the
// receiver cannot stall, so it must take the result then. The words are kept
// twice, in two rows of cells: one row ordered from the front, one ordered
// from the back. A push at one end shifts its own row by one cell and writes
// the word into the first free cell of the other row; a pop at one end shifts
// its own row back and simply shortens the other. The front and back words are
// therefore always sitting in cell 0 of a row, and every cell decides its next
// value from its neighbors, the broadcast command, the shared count and i_value.
// A push on a full queue or a pop on an empty one leaves everything unchanged
// and reports refused. Codes 5 to 7 change nothing and are not refused. Word
// fields read 0 whenever the queue is empty. Stored words are kept in the low
// DATA_WIDTH bits (at most 32); higher bits of the result words are 0.
module double_ended_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    i_operation,
    input  logic [31:0]   i_value,
    output logic          o_valid,
    output logic [31:0]   o_front_word,
    output logic [31:0]   o_back_word,
    output logic          o_words_valid,
    output logic [CW-1:0] o_occupancy,
    output logic          o_is_empty,
    output logic          o_is_full,
    output logic          o_refused
);
    import dqu_pkg::*;

    // stored word width, capped at the port width
    localparam int SW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    logic          w_accept;
    logic          w_empty;
    logic          w_full;
    logic [SW-1:0] w_value;
    logic [SW-1:0] w_front;
    logic [SW-1:0] w_back;

    t_cell_op      w_front_cmd;   // row ordered from the front
    t_cell_op      w_back_cmd;    // row ordered from the back

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_refused;
    logic          n_refused;
    logic          r_valid;

    // every cycle can take a transfer
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_value  = i_value[SW-1:0];
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CW'(DEPTH));

    // Operation decode: commands for both rows, next count and refusal.
    always_comb begin
        w_front_cmd = CELL_HOLD;
        w_back_cmd  = CELL_HOLD;
        n_count     = r_count;
        n_refused   = 1'b0;
        if (w_accept) begin
            unique case (t_op'(i_operation))
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_refused = 1'b1;
                    end else begin
                        w_front_cmd = CELL_PUSH_HEAD;
                        w_back_cmd  = CELL_PUSH_TAIL;
                        n_count     = r_count + CW'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_refused = 1'b1;
                    end else begin
                        w_back_cmd  = CELL_PUSH_HEAD;
                        w_front_cmd = CELL_PUSH_TAIL;
                        n_count     = r_count + CW'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_refused = 1'b1;
                    end else begin
                        // back row just gets shorter
                        w_front_cmd = CELL_POP_HEAD;
                        n_count     = r_count - CW'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        n_refused = 1'b1;
                    end else begin
                        w_back_cmd = CELL_POP_HEAD;
                        n_count    = r_count - CW'(1);
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    // unused codes: no change
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_refused <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
            if (w_accept) begin
                r_refused <= n_refused;
            end
        end
    end

    // Both rows see the count before the operation: a tail push lands in the
    // first free cell.
    dqu_chain #(
        .DEPTH (DEPTH),
        .W     (SW),
        .CW    (CW)
    ) u_front_chain (
        .i_clk       (i_clk),
        .i_cmd       (w_front_cmd),
        .i_value     (w_value),
        .i_count     (r_count),
        .o_head_word (w_front)
    );

    dqu_chain #(
        .DEPTH (DEPTH),
        .W     (SW),
        .CW    (CW)
    ) u_back_chain (
        .i_clk       (i_clk),
        .i_cmd       (w_back_cmd),
        .i_value     (w_value),
        .i_count     (r_count),
        .o_head_word (w_back)
    );

    // Result fields come straight from registers; words read 0 when empty.
    assign o_valid       = r_valid;
    assign o_words_valid = !w_empty;
    assign o_front_word  = w_empty ? '0 : WORD_W'(w_front);
    assign o_back_word   = w_empty ? '0 : WORD_W'(w_back);
    assign o_occupancy   = r_count;
    assign o_is_empty    = w_empty;
    assign o_is_full     = w_full;
    assign o_refused     = r_refused;

endmodule

>>> sv/dqu_checker.sv
// Port-level checks for the double-ended queue unit, bound to the top level.
module dqu_checker #(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic [2:0]    i_operation,
    input logic          o_valid,
    input logic          o_words_valid,
    input logic [CW-1:0] o_occupancy,
    input logic          o_is_empty,
    input logic          o_is_full,
    input logic          o_refused
);
    import dqu_pkg::*;

    // every transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("no result after a transfer");

    // a clear leaves an empty queue and is never refused
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_CLEAR)
            |=> (o_is_empty && !o_words_valid && o_occupancy == '0 && !o_refused))
        else $error("clear did not empty the queue");

    // refusal only happens at an empty or full queue
    a_refuse_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_refused) |-> (o_occupancy == '0 || o_occupancy == CW'(DEPTH)))
        else $error("refused with queue neither empty nor full");

    // flags agree with the count
    a_flags_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_is_empty == (o_occupancy == '0))
                  && (o_is_full == (o_occupancy == CW'(DEPTH)))
                  && (o_words_valid != o_is_empty)))
        else $error("status flags disagree with occupancy");

endmodule

bind double_ended_queue_unit dqu_checker #(
    .DEPTH (DEPTH),
    .CW    (CW)
) u_dqu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_operation   (i_operation),
    .o_valid       (o_valid),
    .o_words_valid (o_words_valid),
    .o_occupancy   (o_occupancy),
    .o_is_empty    (o_is_empty),
    .o_is_full     (o_is_full),
    .o_refused     (o_refused)
);
